// ===== sv/per_channel_time_integrator_core_assert.svh =====
// assertion macros for the per-channel time integrator core
`ifndef PER_CHANNEL_TIME_INTEGRATOR_CORE_ASSERT_SVH
`define PER_CHANNEL_TIME_INTEGRATOR_CORE_ASSERT_SVH

`ifndef SYNTH

// antecedent implies consequent in the same cycle
`define PCTI_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pcti assertion failed");

// antecedent implies consequent in the next cycle
`define PCTI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pcti assertion failed");

`else

`define PCTI_ASSERT_SAME(lbl, ante, cons)
`define PCTI_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== sv/pcti_pkg.sv =====
// shared constants and types of the per-channel time integrator
`default_nettype none

package pcti_pkg;

  localparam int unsigned MaxFreq        = 256;
  localparam int unsigned MaxBeams       = 16;
  localparam int unsigned MaxIntegration = 1024;
  localparam int unsigned MaxTime        = 16777216;

  localparam int unsigned SampleW = 32;
  localparam int unsigned SumW    = 42;
  localparam int unsigned FreqW   = 8;
  localparam int unsigned BeamW   = 4;
  localparam int unsigned CellW   = FreqW + BeamW;
  localparam int unsigned Cells   = MaxFreq * MaxBeams;
  localparam int unsigned SpecW   = 24;
  localparam int unsigned OffW    = 10;

  // raw register widths
  localparam int unsigned LenRegW  = 11;
  localparam int unsigned TimeRegW = 25;
  localparam int unsigned FreqRegW = 9;
  localparam int unsigned BeamRegW = 5;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 25;

  localparam logic [CfgIdxW-1:0] CfgIntegLen = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgTimeCnt  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgFreqCnt  = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgBeamCnt  = 2'd3;

  // item held between the read issue and the write back
  typedef struct packed {
    logic [CellW-1:0]   addr;
    logic [SampleW-1:0] sample;
    logic               first;
    logic               close;
    logic               blk;
    logic               hit;
    logic [SpecW-1:0]   win;
  } s1_t;

endpackage

`default_nettype wire

// ===== sv/per_channel_time_integrator_core.sv =====
// per-channel time integrator: integrate-and-dump over frequency-beam cells
//
//   channel   direction  handshake                  payload
//   in        input      in_valid_i / in_stall_o    sample_i
//   out       output     out_valid_o / out_stall_i  window_sum_o, window_number_o,
//                                                   channel_o, beam_id_o, block_end_o
//   cfg       input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// one sample a cycle sustained while in_stall_o is low; a closing sum passes the write-back
// stage and then the output register. each sample reads its accumulator ram cell once at
// acceptance and writes it once at write-back; back-to-back same-cell hits are forwarded.
// reset clears the counters and sets every register to one; the ram needs no clearing.
// in_stall_o rises only while a closing sum waits for an output register that is stalled.
`default_nettype none

`include "per_channel_time_integrator_core_assert.svh"

module per_channel_time_integrator_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [pcti_pkg::SampleW-1:0]   sample_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [pcti_pkg::SumW-1:0]           window_sum_o,
  output logic [pcti_pkg::SpecW-1:0]          window_number_o,
  output logic [pcti_pkg::FreqW-1:0]          channel_o,
  output logic [pcti_pkg::BeamW-1:0]          beam_id_o,
  output logic                                block_end_o,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [pcti_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [pcti_pkg::CfgDataW-1:0]  cfg_data_i
);

  // configuration, held as limit minus one after clamping
  logic [pcti_pkg::OffW-1:0]  len_m1_q;
  logic [pcti_pkg::SpecW-1:0] tcnt_m1_q;
  logic [pcti_pkg::FreqW-1:0] fcnt_m1_q;
  logic [pcti_pkg::BeamW-1:0] bcnt_m1_q;

  logic [pcti_pkg::LenRegW-1:0]  cfg_len;
  logic [pcti_pkg::TimeRegW-1:0] cfg_time;
  logic [pcti_pkg::FreqRegW-1:0] cfg_freq;
  logic [pcti_pkg::BeamRegW-1:0] cfg_beam;
  logic [pcti_pkg::LenRegW-1:0]  len_clamped;
  logic [pcti_pkg::TimeRegW-1:0] time_clamped;
  logic [pcti_pkg::FreqRegW-1:0] freq_clamped;
  logic [pcti_pkg::BeamRegW-1:0] beam_clamped;

  // position counters
  logic [pcti_pkg::SpecW-1:0] spec_q, spec_d;
  logic [pcti_pkg::FreqW-1:0] freq_q, freq_d;
  logic [pcti_pkg::BeamW-1:0] beam_q, beam_d;
  logic [pcti_pkg::OffW-1:0]  off_q, off_d;
  logic [pcti_pkg::SpecW-1:0] win_q, win_d;

  logic last_spec, last_freq, last_beam, closes;
  logic in_acc;

  // write-back stage
  pcti_pkg::s1_t             s1_q;
  logic                      s1_v_q;
  logic                      s1_adv;
  logic                      s1_we;
  logic [pcti_pkg::SumW-1:0] s1_base;
  logic [pcti_pkg::SumW-1:0] s1_sum;
  logic [pcti_pkg::SumW-1:0] fwd_q;
  logic [pcti_pkg::SumW-1:0] rdata_q;
  logic [pcti_pkg::CellW-1:0] cell_addr;

  logic [pcti_pkg::SumW-1:0] mem [pcti_pkg::Cells];

  // output register
  logic                       out_v_q;
  logic                       out_ready;
  logic [pcti_pkg::SumW-1:0]  out_sum_q;
  logic [pcti_pkg::SpecW-1:0] out_win_q;
  logic [pcti_pkg::CellW-1:0] out_cell_q;
  logic                       out_blk_q;

  // ---------------------------------------------------------------- config
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_len  = cfg_data_i[pcti_pkg::LenRegW-1:0];
    cfg_time = cfg_data_i[pcti_pkg::TimeRegW-1:0];
    cfg_freq = cfg_data_i[pcti_pkg::FreqRegW-1:0];
    cfg_beam = cfg_data_i[pcti_pkg::BeamRegW-1:0];

    if (cfg_len == '0) begin
      len_clamped = pcti_pkg::LenRegW'(1);
    end else if (cfg_len > pcti_pkg::LenRegW'(pcti_pkg::MaxIntegration)) begin
      len_clamped = pcti_pkg::LenRegW'(pcti_pkg::MaxIntegration);
    end else begin
      len_clamped = cfg_len;
    end

    if (cfg_time == '0) begin
      time_clamped = pcti_pkg::TimeRegW'(1);
    end else if (cfg_time > pcti_pkg::TimeRegW'(pcti_pkg::MaxTime)) begin
      time_clamped = pcti_pkg::TimeRegW'(pcti_pkg::MaxTime);
    end else begin
      time_clamped = cfg_time;
    end

    if (cfg_freq == '0) begin
      freq_clamped = pcti_pkg::FreqRegW'(1);
    end else if (cfg_freq > pcti_pkg::FreqRegW'(pcti_pkg::MaxFreq)) begin
      freq_clamped = pcti_pkg::FreqRegW'(pcti_pkg::MaxFreq);
    end else begin
      freq_clamped = cfg_freq;
    end

    if (cfg_beam == '0) begin
      beam_clamped = pcti_pkg::BeamRegW'(1);
    end else if (cfg_beam > pcti_pkg::BeamRegW'(pcti_pkg::MaxBeams)) begin
      beam_clamped = pcti_pkg::BeamRegW'(pcti_pkg::MaxBeams);
    end else begin
      beam_clamped = cfg_beam;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_m1_q  <= '0;
      tcnt_m1_q <= '0;
      fcnt_m1_q <= '0;
      bcnt_m1_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        pcti_pkg::CfgIntegLen: begin
          len_m1_q <= pcti_pkg::OffW'(len_clamped - pcti_pkg::LenRegW'(1));
        end
        pcti_pkg::CfgTimeCnt: begin
          tcnt_m1_q <= pcti_pkg::SpecW'(time_clamped - pcti_pkg::TimeRegW'(1));
        end
        pcti_pkg::CfgFreqCnt: begin
          fcnt_m1_q <= pcti_pkg::FreqW'(freq_clamped - pcti_pkg::FreqRegW'(1));
        end
        pcti_pkg::CfgBeamCnt: begin
          bcnt_m1_q <= pcti_pkg::BeamW'(beam_clamped - pcti_pkg::BeamRegW'(1));
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- handshakes
  assign out_ready  = !out_v_q || !out_stall_i;
  assign s1_adv     = !s1_q.close || out_ready;
  assign in_stall_o = s1_v_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign s1_we      = s1_v_q && s1_adv;

  // ---------------------------------------------------------------- counters
  assign last_spec = spec_q >= tcnt_m1_q;
  assign last_freq = freq_q >= fcnt_m1_q;
  assign last_beam = beam_q >= bcnt_m1_q;
  assign closes    = (off_q >= len_m1_q) || last_spec;
  assign cell_addr = {freq_q, beam_q};

  always_comb begin
    spec_d = spec_q;
    freq_d = freq_q;
    beam_d = beam_q;
    off_d  = off_q;
    win_d  = win_q;
    if (!last_beam) begin
      beam_d = beam_q + pcti_pkg::BeamW'(1);
    end else begin
      beam_d = '0;
      if (!last_freq) begin
        freq_d = freq_q + pcti_pkg::FreqW'(1);
      end else begin
        freq_d = '0;
        // spectrum boundary: advance or close the window, or end the block
        priority if (last_spec) begin
          spec_d = '0;
          off_d  = '0;
          win_d  = '0;
        end else if (closes) begin
          spec_d = spec_q + pcti_pkg::SpecW'(1);
          off_d  = '0;
          win_d  = win_q + pcti_pkg::SpecW'(1);
        end else begin
          spec_d = spec_q + pcti_pkg::SpecW'(1);
          off_d  = off_q + pcti_pkg::OffW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spec_q <= '0;
      freq_q <= '0;
      beam_q <= '0;
      off_q  <= '0;
      win_q  <= '0;
    end else if (in_acc) begin
      spec_q <= spec_d;
      freq_q <= freq_d;
      beam_q <= beam_d;
      off_q  <= off_d;
      win_q  <= win_d;
    end
  end

  // ---------------------------------------------------------------- write-back stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (in_acc) begin
      s1_v_q <= 1'b1;
    end else if (s1_adv) begin
      s1_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q.addr   <= cell_addr;
      s1_q.sample <= sample_i;
      s1_q.first  <= off_q == '0;
      s1_q.close  <= closes;
      s1_q.blk    <= last_spec && last_freq && last_beam;
      // the cell being written this cycle is read stale from the ram
      s1_q.hit    <= s1_we && (s1_q.addr == cell_addr);
      s1_q.win    <= win_q;
    end
  end

  always_comb begin
    priority if (s1_q.first) begin
      s1_base = '0;
    end else if (s1_q.hit) begin
      s1_base = fwd_q;
    end else begin
      s1_base = rdata_q;
    end
    s1_sum = s1_base + pcti_pkg::SumW'(s1_q.sample);
  end

  always_ff @(posedge clk_i) begin
    if (s1_we) begin
      mem[s1_q.addr] <= s1_sum;
      fwd_q          <= s1_sum;
    end
    if (in_acc) begin
      rdata_q <= mem[cell_addr];
    end
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (s1_we && s1_q.close) begin
      out_v_q <= 1'b1;
    end else if (out_ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_we && s1_q.close) begin
      out_sum_q  <= s1_sum;
      out_win_q  <= s1_q.win;
      out_cell_q <= s1_q.addr;
      out_blk_q  <= s1_q.blk;
    end
  end

  assign out_valid_o     = out_v_q;
  assign window_sum_o    = out_sum_q;
  assign window_number_o = out_win_q;
  assign channel_o       = out_cell_q[pcti_pkg::CellW-1:pcti_pkg::BeamW];
  assign beam_id_o       = out_cell_q[pcti_pkg::BeamW-1:0];
  assign block_end_o     = out_blk_q;

  // ---------------------------------------------------------------- assertions
  // a closing sum blocked by the output is kept, not dropped
  `PCTI_ASSERT_NEXT(a_close_held, s1_v_q && s1_q.close && !out_ready, s1_v_q && s1_q.close)
  // a forwarded hit always follows a write of the same cell
  `PCTI_ASSERT_SAME(a_fwd_src, s1_v_q && s1_q.hit && $past(in_acc), $past(s1_we) && ($past(s1_q.addr) == s1_q.addr))
  // the last sample of a block returns every counter to zero
  `PCTI_ASSERT_NEXT(a_block_wrap, in_acc && last_spec && last_freq && last_beam, spec_q == '0 && freq_q == '0 && beam_q == '0 && off_q == '0 && win_q == '0)

endmodule

`default_nettype wire

// ===== test/per_channel_time_integrator_core_tb.sv =====
// self-checking testbench of the per-channel time integrator core
`default_nettype none

module per_channel_time_integrator_core_tb;

  localparam int unsigned StallLimit = 1000;
  localparam int unsigned ShowLimit  = 10;
  localparam int unsigned ItemTarget = 650;
  localparam int unsigned SettleCyc  = 4;

  typedef struct packed {
    logic [pcti_pkg::SumW-1:0]  sum;
    logic [pcti_pkg::SpecW-1:0] win;
    logic [pcti_pkg::FreqW-1:0] ch;
    logic [pcti_pkg::BeamW-1:0] beam;
    logic                       blk;
  } window_result_t;

  typedef enum bit {ROW_WRITE, ROW_SAMPLE} row_kind_e;

  typedef struct packed {
    row_kind_e                      kind;
    logic [pcti_pkg::CfgIdxW-1:0]   idx;
    logic [pcti_pkg::CfgDataW-1:0]  data;
    logic [pcti_pkg::SampleW-1:0]   smp;
    bit                             typed;
    window_result_t                 want;
  } stim_row_t;

  localparam logic [pcti_pkg::CfgIdxW-1:0] RegOrder [4] = '{
    pcti_pkg::CfgIntegLen, pcti_pkg::CfgTimeCnt, pcti_pkg::CfgFreqCnt, pcti_pkg::CfgBeamCnt
  };

  // directed walk: defaults, register zero and saturation, partial final window,
  // mid-block changes and the start of a fresh block
  stim_row_t directed_rows [40] = '{
    '{ROW_SAMPLE, pcti_pkg::CfgIntegLen, 25'd0, 32'h0000_0000, 1'b1,
      '{42'h0, 24'd0, 8'd0, 4'd0, 1'b1}},
    '{ROW_SAMPLE, pcti_pkg::CfgIntegLen, 25'd0, 32'hFFFF_FFFF, 1'b1,
      '{42'hFFFF_FFFF, 24'd0, 8'd0, 4'd0, 1'b1}},
    '{ROW_SAMPLE, pcti_pkg::CfgIntegLen, 25'd0, 32'h0000_0001, 1'b1,
      '{42'h1, 24'd0, 8'd0, 4'd0, 1'b1}},
    '{ROW_WRITE,  pcti_pkg::CfgIntegLen, 25'd0, 32'h0, 1'b0, '0},
    '{ROW_WRITE,  pcti_pkg::CfgTimeCnt,  25'd0, 32'h0, 1'b0, '0},
    '{ROW_WRITE,  pcti_pkg::CfgFreqCnt,  25'd0, 32'h0, 1'b0, '0},
    '{ROW_WRITE,  pcti_pkg::CfgBeamCnt,  25'd0, 32'h0, 1'b0, '0},
    '{ROW_SAMPLE, pcti_pkg::CfgIntegLen, 25'd0, 32'h8000_0000, 1'b1,
      '{42'h8000_0000, 24'd0, 8'd0, 4'd0, 1'b1}},
    '{ROW_WRITE,  pcti_pkg::CfgFreqCnt,  25'd2, 32'h0, 1'b0, '0},
    '{ROW_WRITE,  pcti_pkg::CfgBeamCnt,  25'd1, 32'h0, 1'b0, '0},
    '{ROW_WRITE,  pcti_pkg::CfgIntegLen, 25'd2, 32'h0, 1'b0, '0},
    '{ROW_WRITE,  pcti_pkg::CfgTimeCnt,  25'd3, 32'h0, 1'b0, '0},
    '{ROW_SAMPLE, pcti_pkg::CfgIntegLen, 25'd0, 32'hFFFF_FFFF, 1'b0, '0},
    '{ROW_SAMPLE, pcti_pkg::CfgIntegLen, 25'd0, 32'hFFFF_FFFF, 1'b0, '0},
    '{ROW_SAMPLE, pcti_pkg::CfgIntegLen, 25'd0, 32'h1234_5678, 1'b0, '0},
    '{ROW_SAMPLE, pcti_pkg::CfgIntegLen, 25'd0, 32'hFFFF_FFFF, 1'b0, '0},
    '{ROW_SAMPLE, pcti_pkg::CfgIntegLen, 25'd0, 32'h0000_0000, 1'b0, '0},
    '{ROW_SAMPLE, pcti_pkg::CfgIntegLen, 25'd0, 32'hFFFF_FFFF, 1'b0, '0},
    '{ROW_WRITE,  pcti_pkg::CfgIntegLen, 25'd2047, 32'h0, 1'b0, '0},
    '{ROW_WRITE,  pcti_pkg::CfgTimeCnt,  25'h1FF_FFFF, 32'h0, 1'b0, '0},
    '{ROW_WRITE,  pcti_pkg::CfgFreqCnt,  25'd511, 32'h0, 1'b0, '0},
    '{ROW_WRITE,  pcti_pkg::CfgBeamCnt,  25'd31, 32'h0, 1'b0, '0},
    '{ROW_SAMPLE, pcti_pkg::CfgIntegLen, 25'd0, 32'h5555_5555, 1'b0, '0},
    '{ROW_SAMPLE, pcti_pkg::CfgIntegLen, 25'd0, 32'hAAAA_AAAA, 1'b0, '0},
    '{ROW_SAMPLE, pcti_pkg::CfgIntegLen, 25'd0, 32'h0F0F_0F0F, 1'b0, '0},
    // shrink everything mid-spectrum: the next sample closes and ends the block
    '{ROW_WRITE,  pcti_pkg::CfgIntegLen, 25'd0, 32'h0, 1'b0, '0},
    '{ROW_WRITE,  pcti_pkg::CfgTimeCnt,  25'd0, 32'h0, 1'b0, '0},
    '{ROW_WRITE,  pcti_pkg::CfgFreqCnt,  25'd0, 32'h0, 1'b0, '0},
    '{ROW_WRITE,  pcti_pkg::CfgBeamCnt,  25'd0, 32'h0, 1'b0, '0},
    '{ROW_SAMPLE, pcti_pkg::CfgIntegLen, 25'd0, 32'hDEAD_BEEF, 1'b0, '0},
    '{ROW_SAMPLE, pcti_pkg::CfgIntegLen, 25'd0, 32'hFFFF_FFFF, 1'b1,
      '{42'hFFFF_FFFF, 24'd0, 8'd0, 4'd0, 1'b1}},
    '{ROW_WRITE,  pcti_pkg::CfgIntegLen, 25'd4, 32'h0, 1'b0, '0},
    '{ROW_WRITE,  pcti_pkg::CfgTimeCnt,  25'd8, 32'h0, 1'b0, '0},
    '{ROW_SAMPLE, pcti_pkg::CfgIntegLen, 25'd0, 32'hFFFF_FFFF, 1'b0, '0},
    '{ROW_SAMPLE, pcti_pkg::CfgIntegLen, 25'd0, 32'hFFFF_FFFE, 1'b0, '0},
    '{ROW_SAMPLE, pcti_pkg::CfgIntegLen, 25'd0, 32'h0000_0003, 1'b0, '0},
    // window shortened below the running offset
    '{ROW_WRITE,  pcti_pkg::CfgIntegLen, 25'd2, 32'h0, 1'b0, '0},
    '{ROW_SAMPLE, pcti_pkg::CfgIntegLen, 25'd0, 32'h7FFF_FFFF, 1'b0, '0},
    '{ROW_WRITE,  pcti_pkg::CfgTimeCnt,  25'd0, 32'h0, 1'b0, '0},
    '{ROW_SAMPLE, pcti_pkg::CfgIntegLen, 25'd0, 32'h0000_0100, 1'b0, '0}
  };

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic [pcti_pkg::SampleW-1:0]  sample_i;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic [pcti_pkg::SumW-1:0]     window_sum_o;
  logic [pcti_pkg::SpecW-1:0]    window_number_o;
  logic [pcti_pkg::FreqW-1:0]    channel_o;
  logic [pcti_pkg::BeamW-1:0]    beam_id_o;
  logic                          block_end_o;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [pcti_pkg::CfgIdxW-1:0]  cfg_index_i;
  logic [pcti_pkg::CfgDataW-1:0] cfg_data_i;

  // integrator state as the block should hold it
  bit [pcti_pkg::SumW-1:0]     cell_sum [pcti_pkg::Cells];
  bit [pcti_pkg::SpecW-1:0]    spec_idx;
  bit [pcti_pkg::FreqW-1:0]    freq_pos;
  bit [pcti_pkg::BeamW-1:0]    beam_pos;
  bit [pcti_pkg::OffW-1:0]     win_off;
  bit [pcti_pkg::SpecW-1:0]    win_cnt;
  bit [pcti_pkg::LenRegW-1:0]  len_reg;
  bit [pcti_pkg::TimeRegW-1:0] time_reg;
  bit [pcti_pkg::FreqRegW-1:0] freq_reg;
  bit [pcti_pkg::BeamRegW-1:0] beam_reg;

  window_result_t sums_due [$];

  bit          tx_gaps_on;
  bit          rx_stall_on;
  int unsigned rx_hold = 0;
  int unsigned samples_sent = 0;
  int unsigned sums_seen = 0;
  int unsigned reg_writes = 0;
  int unsigned settings_used = 0;
  int unsigned mid_changes = 0;
  int unsigned mismatches = 0;

  per_channel_time_integrator_core i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .sample_i,
    .out_valid_o,
    .out_stall_i,
    .window_sum_o,
    .window_number_o,
    .channel_o,
    .beam_id_o,
    .block_end_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int unsigned eff_count(int unsigned raw, int unsigned hi);
    if (raw == 0) return 1;
    if (raw > hi) return hi;
    return raw;
  endfunction

  function automatic bit at_block_start();
    return spec_idx == '0 && freq_pos == '0 && beam_pos == '0 && win_off == '0;
  endfunction

  // one read-add-write on the current cell, then advance beam, channel, spectrum
  function automatic bit integrate_sample(input logic [pcti_pkg::SampleW-1:0] s,
                                          output window_result_t r);
    int unsigned             len_e, time_e, freq_e, beam_e, cell_ix;
    bit [pcti_pkg::SumW-1:0] total;
    bit                      last_spec, last_freq, last_beam, closes;
    len_e   = eff_count(len_reg, pcti_pkg::MaxIntegration);
    time_e  = eff_count(time_reg, pcti_pkg::MaxTime);
    freq_e  = eff_count(freq_reg, pcti_pkg::MaxFreq);
    beam_e  = eff_count(beam_reg, pcti_pkg::MaxBeams);
    cell_ix = freq_pos * pcti_pkg::MaxBeams + beam_pos;
    if (win_off == '0) total = pcti_pkg::SumW'(s);
    else total = cell_sum[cell_ix] + pcti_pkg::SumW'(s);
    cell_sum[cell_ix] = total;
    last_spec = spec_idx >= time_e - 1;
    last_freq = freq_pos >= freq_e - 1;
    last_beam = beam_pos >= beam_e - 1;
    closes    = (win_off >= len_e - 1) || last_spec;
    r = '{total, win_cnt, freq_pos, beam_pos, last_spec && last_freq && last_beam};
    if (!last_beam) begin
      beam_pos++;
    end else begin
      beam_pos = '0;
      if (!last_freq) begin
        freq_pos++;
      end else begin
        freq_pos = '0;
        if (last_spec) begin
          spec_idx = '0;
          win_off  = '0;
          win_cnt  = '0;
        end else begin
          spec_idx++;
          if (closes) begin
            win_off = '0;
            win_cnt++;
          end else begin
            win_off++;
          end
        end
      end
    end
    return closes;
  endfunction

  function automatic int unsigned pick_setting(logic [pcti_pkg::CfgIdxW-1:0] idx);
    int unsigned raw_max, limit, common_hi;
    case (idx)
      pcti_pkg::CfgIntegLen: begin
        raw_max = (1 << pcti_pkg::LenRegW) - 1; limit = pcti_pkg::MaxIntegration;
        common_hi = 6;
      end
      pcti_pkg::CfgTimeCnt: begin
        raw_max = (1 << pcti_pkg::TimeRegW) - 1; limit = pcti_pkg::MaxTime;
        common_hi = 8;
      end
      pcti_pkg::CfgFreqCnt: begin
        raw_max = (1 << pcti_pkg::FreqRegW) - 1; limit = pcti_pkg::MaxFreq;
        common_hi = 4;
      end
      default: begin
        raw_max = (1 << pcti_pkg::BeamRegW) - 1; limit = pcti_pkg::MaxBeams;
        common_hi = 4;
      end
    endcase
    case ($urandom_range(0, 9))
      0: return 0;
      1: return raw_max;
      2: return limit;
      3: return $urandom_range(0, raw_max);
      default: return $urandom_range(1, common_hi);
    endcase
  endfunction

  // called at a falling edge, returns at a falling edge with valid still high
  task automatic send_sample(input logic [pcti_pkg::SampleW-1:0] s, input bit typed,
                             input window_result_t want);
    int unsigned    gap;
    window_result_t r;
    gap = tx_gaps_on ? $urandom_range(0, 8) : 0;
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    sample_i   = s;
    do @(posedge clk_i); while (in_stall_o);
    if (integrate_sample(s, r) && !typed) sums_due.push_back(r);
    if (typed) sums_due.push_back(want);
    samples_sent++;
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [pcti_pkg::CfgIdxW-1:0] idx,
                           input int unsigned value);
    logic [pcti_pkg::CfgDataW-1:0] data;
    data        = pcti_pkg::CfgDataW'(value);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      pcti_pkg::CfgIntegLen: len_reg  = data[pcti_pkg::LenRegW-1:0];
      pcti_pkg::CfgTimeCnt:  time_reg = data[pcti_pkg::TimeRegW-1:0];
      pcti_pkg::CfgFreqCnt:  freq_reg = data[pcti_pkg::FreqRegW-1:0];
      default:               beam_reg = data[pcti_pkg::BeamRegW-1:0];
    endcase
    reg_writes++;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // sender holds off until every window sum is in, plus the pipeline depth
  task automatic wait_idle();
    in_valid_i = 1'b0;
    while (sums_due.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // receiver: random stall after each transaction while rx_stall_on is set
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) rx_hold <= rx_stall_on ? $urandom_range(0, 8) : 0;
    else if (rx_hold != 0) rx_hold <= rx_hold - 1;
  end

  always @(negedge clk_i) out_stall_i <= (rx_hold != 0);

  always @(posedge clk_i) begin
    window_result_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{window_sum_o, window_number_o, channel_o, beam_id_o, block_end_o};
      sums_seen++;
      if (sums_due.size() == 0) begin
        mismatches++;
        if (mismatches <= ShowLimit)
          $display("unexpected window sum %0h win %0d ch %0d beam %0d end %0b",
                   got.sum, got.win, got.ch, got.beam, got.blk);
      end else begin
        want = sums_due.pop_front();
        if (got.sum !== want.sum || got.win !== want.win || got.ch !== want.ch ||
            got.beam !== want.beam || got.blk !== want.blk) begin
          mismatches++;
          if (mismatches <= ShowLimit) begin
            $display("mismatch: exp sum %0h win %0d ch %0d beam %0d end %0b",
                     want.sum, want.win, want.ch, want.beam, want.blk);
            $display("          got sum %0h win %0d ch %0d beam %0d end %0b",
                     got.sum, got.win, got.ch, got.beam, got.blk);
          end
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end
    $display("timeout: no transaction for %0d cycles", StallLimit);
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    row_kind_e   prev_kind;
    int unsigned phase_len;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    sample_i    = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = pcti_pkg::CfgIntegLen;
    cfg_data_i  = '0;
    tx_gaps_on  = 1'b1;
    rx_stall_on = 1'b1;
    spec_idx = '0; freq_pos = '0; beam_pos = '0; win_off = '0; win_cnt = '0;
    len_reg = 1; time_reg = 1; freq_reg = 1; beam_reg = 1;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    prev_kind = ROW_WRITE;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        if (prev_kind == ROW_SAMPLE) wait_idle();
        write_reg(directed_rows[i].idx, directed_rows[i].data);
      end else begin
        send_sample(directed_rows[i].smp, directed_rows[i].typed, directed_rows[i].want);
      end
      prev_kind = directed_rows[i].kind;
    end

    while (samples_sent < ItemTarget) begin
      wait_idle();
      if (!at_block_start() && $urandom_range(0, 2) == 0) begin
        // only shrink the cell grid mid-block so no cell is read before it is written
        write_reg(pcti_pkg::CfgIntegLen, pick_setting(pcti_pkg::CfgIntegLen));
        write_reg(pcti_pkg::CfgTimeCnt, pick_setting(pcti_pkg::CfgTimeCnt));
        if ($urandom_range(0, 1) != 0)
          write_reg(pcti_pkg::CfgFreqCnt,
                    $urandom_range(0, eff_count(freq_reg, pcti_pkg::MaxFreq)));
        if ($urandom_range(0, 1) != 0)
          write_reg(pcti_pkg::CfgBeamCnt,
                    $urandom_range(0, eff_count(beam_reg, pcti_pkg::MaxBeams)));
        mid_changes++;
      end else begin
        if (!at_block_start()) begin
          // collapse to one cell and one spectrum so the next sample ends the block
          write_reg(pcti_pkg::CfgFreqCnt, 0);
          write_reg(pcti_pkg::CfgBeamCnt, 0);
          write_reg(pcti_pkg::CfgTimeCnt, 0);
          send_sample($urandom, 1'b0, '0);
          wait_idle();
        end
        foreach (RegOrder[k]) write_reg(RegOrder[k], pick_setting(RegOrder[k]));
      end
      settings_used++;
      tx_gaps_on  = $urandom_range(0, 3) != 0;
      rx_stall_on = $urandom_range(0, 3) != 0;
      phase_len   = $urandom_range(8, 60);
      repeat (phase_len) begin
        case ($urandom_range(0, 9))
          0:       send_sample('0, 1'b0, '0);
          1:       send_sample('1, 1'b0, '0);
          default: send_sample($urandom, 1'b0, '0);
        endcase
      end
    end

    wait_idle();
    $display("ran %0d samples, checked %0d window sums, %0d register writes",
             samples_sent, sums_seen, reg_writes);
    $display("%0d random settings, %0d of them changed mid-block",
             settings_used, mid_changes);
    if (mismatches == 0 && sums_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d window sums missing", mismatches, sums_due.size());
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
